[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the dispatch unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/core/pdrp_pkg.sv]
// Package of types and codes for the priority dispatch unit.
package pdrp_pkg;
   localparam logic [1:0] OP_ADD_RES = 2'd0;
   localparam logic [1:0] OP_ADD_REQ = 2'd1;
   localparam logic [1:0] OP_PROCESS = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_QFULL    = 3'd1;
   localparam logic [2:0] ST_NOREQ    = 3'd2;
   localparam logic [2:0] ST_NOFREE   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_ALREADY  = 3'd5;
   localparam logic [2:0] ST_BADTYPE  = 3'd6;
   localparam logic [2:0] ST_POOLFULL = 3'd7;

   localparam logic [1:0] TYPE_INVALID = 2'd3;
   localparam logic [1:0] SEV_HIGH     = 2'd3;
   localparam logic [1:0] SEV_MED      = 2'd2;

   // Queue entry: id, severity, type, zone (35 bits).
   typedef struct packed {
      logic [15:0] id;
      logic [1:0]  sev;
      logic [1:0]  rtype;
      logic [14:0] zone;
   } qent_type;

   // Pool entry: type, number, busy flag.
   typedef struct packed {
      logic [1:0] rtype;
      logic [9:0] number;
      logic       busy;
   } pent_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] request_id;
      logic [1:0]  granted_type;
      logic [9:0]  granted_number;
      logic [1:0]  req_severity;
      logic [14:0] req_zone;
   } rsp_type;
endpackage

[rtl/core/pdrp_ram.sv]
// Generic single-port-write, registered-read RAM.
module pdrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/priority_dispatch_with_resource_pool_unit.sv]
// Strict-priority three-queue dispatcher with a bounded resource pool.
// Add resource and add request finish without a pool scan; release and process may scan
// the pool memory serially, newest entry first, each entry taking a read state and a
// check state (S_SRD, S_SCHK). One command at a time: a new command is accepted in the
// cycle after the response is taken.
// Reset is synchronous and active high: queues and pool read as empty, counter zero.
module priority_dispatch_with_resource_pool_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int POOL_SIZE   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, from bit 0: opcode[1:0], severity[3:2], res_type[5:4],
   // zone_id[20:6], res_number[30:21], zero fill[31].
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, from bit 0: status[2:0], request_id[18:3], granted_type[20:19],
   // granted_number[30:21], req_severity[32:31], req_zone[47:33].
   output logic [47:0] rsp_tdata
);
   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PAW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int PCW = $clog2(POOL_SIZE + 1);
   localparam int QW  = $bits(pdrp_pkg::qent_type);
   localparam int PW  = $bits(pdrp_pkg::pent_type);

   // One-hot sequencer. The queue memory is shared by the three queues,
   // each owning a slice of 2**QAW entries addressed by its queue number.
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_QRD  = 7'b0000010,
      S_QDAT = 7'b0000100,
      S_SRD  = 7'b0001000,
      S_SCHK = 7'b0010000,
      S_DONE = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in, sev_ff, sev_in, typ_ff, typ_in;
   logic [14:0] zone_ff, zone_in;
   logic [9:0]  num_ff, num_in;
   logic [QAW-1:0] head_ff [3], head_in [3];
   logic [QCW-1:0] cnt_ff [3], cnt_in [3];
   logic [15:0] ctr_ff, ctr_in;
   logic [PCW-1:0] pcnt_ff, pcnt_in;
   logic [PCW-1:0] scan_ff, scan_in;      // entries still to look at
   logic [1:0]  qsel_ff, qsel_in;
   pdrp_pkg::rsp_type rsp_ff, rsp_in;
   pdrp_pkg::qent_type qrd;
   pdrp_pkg::pent_type prd;

   logic           q_we, p_we;
   logic [QAW+1:0] q_waddr, q_raddr;
   logic [QW-1:0]  q_wdata, q_rdata;
   logic [PAW-1:0] p_waddr, p_raddr;
   logic [PW-1:0]  p_wdata, p_rdata;

   pdrp_ram #(.WIDTH(QW), .DEPTH(4 * (2 ** QAW))) u_qram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));
   pdrp_ram #(.WIDTH(PW), .DEPTH(2 ** PAW)) u_pram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata));

   assign qrd = pdrp_pkg::qent_type'(q_rdata);
   assign prd = pdrp_pkg::pent_type'(p_rdata);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {rsp_ff.req_zone, rsp_ff.req_severity, rsp_ff.granted_number,
                       rsp_ff.granted_type, rsp_ff.request_id, rsp_ff.status};

   logic [PCW-1:0] scan_m1;
   logic [QAW:0]   tail_sum;
   logic [QAW-1:0] tail_idx;
   assign scan_m1  = scan_ff - PCW'(1);
   assign tail_sum = (QAW+1)'(head_ff[qsel_ff]) + (QAW+1)'(cnt_ff[qsel_ff]);
   // Head plus count stays below twice the depth, so one subtract wraps it.
   assign tail_idx = (tail_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
                     QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; sev_in = sev_ff; typ_in = typ_ff; zone_in = zone_ff; num_in = num_ff;
      head_in = head_ff; cnt_in = cnt_ff; ctr_in = ctr_ff; pcnt_in = pcnt_ff;
      scan_in = scan_ff; qsel_in = qsel_ff; rsp_in = rsp_ff;
      q_we = 1'b0; q_waddr = {qsel_ff, head_ff[qsel_ff]}; q_raddr = {qsel_ff, head_ff[qsel_ff]};
      q_wdata = '0;
      p_we = 1'b0; p_waddr = scan_m1[PAW-1:0]; p_raddr = scan_m1[PAW-1:0];
      p_wdata = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tdata[1:0];
               sev_in  = req_tdata[3:2];
               typ_in  = req_tdata[5:4];
               zone_in = req_tdata[20:6];
               num_in  = req_tdata[30:21];
               rsp_in  = '0;
               state_in = S_QRD;
            end
         end
         S_QRD: begin
            // Decode the command; add resource writes the pool and process starts the queue read.
            scan_in = pcnt_ff;
            unique case (op_ff)
               pdrp_pkg::OP_ADD_RES: begin
                  if (typ_ff == pdrp_pkg::TYPE_INVALID) begin
                     rsp_in.status = pdrp_pkg::ST_BADTYPE;
                  end else if (pcnt_ff >= PCW'(POOL_SIZE)) begin
                     rsp_in.status = pdrp_pkg::ST_POOLFULL;
                  end else begin
                     p_we = 1'b1;
                     p_waddr = pcnt_ff[PAW-1:0];
                     p_wdata = {typ_ff, num_ff, 1'b0};
                     pcnt_in = pcnt_ff + PCW'(1);
                     rsp_in.granted_type = typ_ff;
                     rsp_in.granted_number = num_ff;
                  end
                  state_in = S_OUT;
               end
               pdrp_pkg::OP_ADD_REQ: begin
                  ctr_in = ctr_ff + 16'd1;
                  rsp_in.request_id = ctr_ff + 16'd1;
                  rsp_in.req_severity = sev_ff;
                  rsp_in.req_zone = zone_ff;
                  qsel_in = (sev_ff == pdrp_pkg::SEV_HIGH) ? 2'd0 :
                            (sev_ff == pdrp_pkg::SEV_MED) ? 2'd1 : 2'd2;
                  state_in = S_DONE;
               end
               pdrp_pkg::OP_PROCESS: begin
                  priority if (cnt_ff[0] != '0) qsel_in = 2'd0;
                  else if (cnt_ff[1] != '0) qsel_in = 2'd1;
                  else if (cnt_ff[2] != '0) qsel_in = 2'd2;
                  else qsel_in = 2'd3;
                  q_raddr = {qsel_in, head_ff[qsel_in[1:0] == 2'd3 ? 2'd0 : qsel_in]};
                  if (qsel_in == 2'd3) begin
                     rsp_in.status = pdrp_pkg::ST_NOREQ;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_QDAT;
                  end
               end
               pdrp_pkg::OP_RELEASE: begin
                  if (typ_ff == pdrp_pkg::TYPE_INVALID) begin
                     rsp_in.status = pdrp_pkg::ST_BADTYPE;
                     state_in = S_OUT;
                  end else begin
                     rsp_in.status = pdrp_pkg::ST_NOTFOUND;
                     state_in = S_SRD;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_QDAT: begin
            // Pop the head entry just read.
            head_in[qsel_ff] = (head_ff[qsel_ff] == QAW'(QUEUE_DEPTH - 1)) ? '0 :
                               head_ff[qsel_ff] + QAW'(1);
            cnt_in[qsel_ff] = cnt_ff[qsel_ff] - QCW'(1);
            rsp_in.request_id = qrd.id;
            rsp_in.req_severity = qrd.sev;
            rsp_in.req_zone = qrd.zone;
            rsp_in.granted_type = qrd.rtype;
            typ_in = qrd.rtype;
            rsp_in.status = pdrp_pkg::ST_NOFREE;
            state_in = S_SRD;
         end
         S_SRD: begin
            // Issue a read of the next entry, newest first.
            if (scan_ff == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            scan_in = scan_m1;
            state_in = S_SRD;
            if (op_ff == pdrp_pkg::OP_PROCESS) begin
               if (prd.rtype == typ_ff && !prd.busy) begin
                  p_we = 1'b1;
                  p_wdata = {prd.rtype, prd.number, 1'b1};
                  rsp_in.granted_number = prd.number;
                  rsp_in.status = pdrp_pkg::ST_OK;
                  state_in = S_OUT;
               end
            end else if (prd.rtype == typ_ff && prd.number == num_ff) begin
               p_we = prd.busy;
               p_wdata = {prd.rtype, prd.number, 1'b0};
               rsp_in.status = prd.busy ? pdrp_pkg::ST_OK : pdrp_pkg::ST_ALREADY;
               rsp_in.granted_type = typ_ff;
               rsp_in.granted_number = num_ff;
               state_in = S_OUT;
            end
         end
         S_DONE: begin
            // Push into the chosen queue unless it is full.
            if (cnt_ff[qsel_ff] >= QCW'(QUEUE_DEPTH)) begin
               rsp_in.status = pdrp_pkg::ST_QFULL;
            end else begin
               q_we = 1'b1;
               q_waddr = {qsel_ff, tail_idx};
               q_wdata = {rsp_ff.request_id, sev_ff, typ_ff, zone_ff};
               cnt_in[qsel_ff] = cnt_ff[qsel_ff] + QCW'(1);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '{default: '0};
         cnt_ff   <= '{default: '0};
         ctr_ff   <= '0;
         pcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         ctr_ff   <= ctr_in;
         pcnt_ff  <= pcnt_in;
      end
      op_ff <= op_in; sev_ff <= sev_in; typ_ff <= typ_in; zone_ff <= zone_in;
      num_ff <= num_in; scan_ff <= scan_in; qsel_ff <= qsel_in; rsp_ff <= rsp_in;
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_pool_bound, clock, reset, 1'b1, pcnt_ff <= PCW'(POOL_SIZE), "pool overflow")
   `ASSERT_IMPL(a_one_side, clock, reset, 1'b1, !(req_tready && rsp_tvalid), "both sides open")
   `ASSERT_NEXT(a_ctr_step, clock, reset, state_ff == S_QRD && op_ff == pdrp_pkg::OP_ADD_REQ, ctr_ff == $past(ctr_ff) + 16'd1, "counter did not advance")
endmodule
